FILE: src/c2p_pkg.sv
// Shared types, codes and the bitplane conversion function of the chunky-to-planar unit.
`default_nettype none

package c2p_pkg;

  // Frame limits
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned Planes    = 4;

  // Field widths
  localparam int unsigned WidthW   = 13;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned StrideW  = 16;
  localparam int unsigned PitchW   = 12;
  localparam int unsigned OffsetW  = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BLOCK  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_DIM     = 2'd1;
  localparam logic [1:0] ST_BAD_STRIDE  = 2'd2;
  localparam logic [1:0] ST_NOT_RUNNING = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_STRIDE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PLANE_PITCH   = 3'd4;

  typedef logic [Planes-1:0][31:0] planes_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    planes_t            planes;
    logic [OffsetW-1:0] dest_offset;
    logic               last_block;
  } result_t;

  // Gather 32 pixels from the buffered words and split them into bitplanes.
  // Packed: {b0, word} holds 32 nibbles, high nibble first.
  // Byte mode: {b0, b1, b2, word} holds 32 bytes, low nibble used.
  function automatic planes_t c2p_planes(input logic        byte_mode,
                                         input logic [63:0] b0,
                                         input logic [63:0] b1,
                                         input logic [63:0] b2,
                                         input logic [63:0] word);
    logic [127:0] packed_cat;
    logic [255:0] byte_cat;
    logic [3:0]   px;
    planes_t      pl;
    packed_cat = {b0, word};
    byte_cat   = {b0, b1, b2, word};
    pl         = '0;
    for (int i = 0; i < 32; i++) begin
      if (byte_mode) begin
        px = byte_cat[251 - 8*i -: 4];
      end else begin
        px = packed_cat[127 - 4*i -: 4];
      end
      for (int k = 0; k < Planes; k++) begin
        pl[k][31 - i] = px[k];
      end
    end
    return pl;
  endfunction

endpackage

`default_nettype wire

FILE: src/c2p_if.sv
// Channel interfaces of the chunky-to-planar unit: input, result and configuration write.
`default_nettype none

interface c2p_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

interface c2p_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [1:0]                    status;
  logic [31:0]                   plane_zero;
  logic [31:0]                   plane_one;
  logic [31:0]                   plane_two;
  logic [31:0]                   plane_three;
  logic [c2p_pkg::OffsetW-1:0]   dest_offset;
  logic                          last_block;

  modport source (output valid, output kind, output status, output plane_zero,
                  output plane_one, output plane_two, output plane_three,
                  output dest_offset, output last_block, input ready);
  modport sink   (input valid, input kind, input status, input plane_zero,
                  input plane_one, input plane_two, input plane_three,
                  input dest_offset, input last_block, output ready);
endinterface

interface c2p_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [c2p_pkg::CfgIdxW-1:0]    reg_index;
  logic [c2p_pkg::CfgDataW-1:0]   wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: src/c2p_out_skid.sv
// Result output register with a skid stage that takes one more result while the output stalls.
`default_nettype none

module c2p_out_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire c2p_pkg::result_t res_i,
  output logic                  res_ready_o,
  c2p_out_if.source             out_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  c2p_pkg::result_t out_q;
  c2p_pkg::result_t skid_q;
  logic             out_free;

  // Output register can load when empty or being drained this cycle
  assign out_free    = !out_valid_q || out_o.ready;
  assign res_ready_o = !skid_valid_q;

  // Control: output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: advance skid into output, or park a new result in the skid
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i && !skid_valid_q) begin
      skid_q <= res_i;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.status      = out_q.status;
  assign out_o.plane_zero  = out_q.planes[0];
  assign out_o.plane_one   = out_q.planes[1];
  assign out_o.plane_two   = out_q.planes[2];
  assign out_o.plane_three = out_q.planes[3];
  assign out_o.dest_offset = out_q.dest_offset;
  assign out_o.last_block  = out_q.last_block;

endmodule

`default_nettype wire

FILE: src/chunky_to_planar_4bit_unit.sv
// Top level of the 4-bit chunky-to-planar converter.
//
//   channel  | dir | transaction
//   ---------+-----+--------------------------------------------------------
//   in_i     | in  | command (start / data) and one 64-bit source data word
//   out_o    | out | status response or one block of four 32-bit plane words
//   cfg_i    | in  | register index and write data, always ready
//
// One transaction is accepted per cycle while in_i.ready is high; its result, if any,
// is registered before it reaches out_o. in_i.ready drops only while the
// skid stage holds a result behind a stalled output register. Reset clears
// the configuration to its defaults and stops the frame; the word buffer has
// no reset. A packed block completes on its 2nd data word, a byte-mode block
// on its 4th.
`default_nettype none

module chunky_to_planar_4bit_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c2p_in_if.sink     in_i,
  c2p_out_if.source  out_o,
  c2p_cfg_if.sink    cfg_i
);

  // Configuration registers
  logic                          fmt_q;
  logic [c2p_pkg::WidthW-1:0]    width_q;
  logic [c2p_pkg::HeightW-1:0]   height_q;
  logic [c2p_pkg::StrideW-1:0]   stride_q;
  logic [c2p_pkg::PitchW-1:0]    pitch_q;

  // Frame state
  logic                          running_q, running_d;
  logic [1:0]                    wc_q, wc_d;
  logic [6:0]                    blk_q, blk_d;
  logic [11:0]                   row_q, row_d;
  logic [c2p_pkg::OffsetW-1:0]   base_q, base_d;
  logic [63:0]                   buf_q [3];

  logic                          in_fire;
  logic                          res_valid;
  logic                          res_ready;
  c2p_pkg::result_t              res;
  logic                          buf_we;
  logic [1:0]                    buf_idx;
  logic [1:0]                    check_code;
  logic [c2p_pkg::WidthW-1:0]    need_bytes;
  logic [7:0]                    blocks;
  logic                          row_end;
  logic                          frame_end;
  logic                          block_done;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = res_ready;
  assign in_fire     = in_i.valid && res_ready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      width_q  <= c2p_pkg::WidthW'(32);
      height_q <= c2p_pkg::HeightW'(1);
      stride_q <= c2p_pkg::StrideW'(16);
      pitch_q  <= c2p_pkg::PitchW'(4);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        c2p_pkg::REG_PIXEL_FORMAT:  fmt_q    <= cfg_i.wr_data[0];
        c2p_pkg::REG_FRAME_WIDTH:   width_q  <= cfg_i.wr_data[c2p_pkg::WidthW-1:0];
        c2p_pkg::REG_FRAME_HEIGHT:  height_q <= cfg_i.wr_data[c2p_pkg::HeightW-1:0];
        c2p_pkg::REG_SOURCE_STRIDE: stride_q <= cfg_i.wr_data[c2p_pkg::StrideW-1:0];
        c2p_pkg::REG_PLANE_PITCH:   pitch_q  <= cfg_i.wr_data[c2p_pkg::PitchW-1:0];
        default: ;
      endcase
    end
  end

  // Frame geometry check: dimensions first, then strides
  assign need_bytes = fmt_q ? width_q : {1'b0, width_q[c2p_pkg::WidthW-1:1]};
  always_comb begin
    if (width_q == '0 || height_q == '0 || width_q[4:0] != 5'd0 ||
        width_q > c2p_pkg::WidthW'(c2p_pkg::MaxWidth) ||
        height_q > c2p_pkg::HeightW'(c2p_pkg::MaxHeight)) begin
      check_code = c2p_pkg::ST_BAD_DIM;
    end else if (stride_q < {3'd0, need_bytes} ||
                 pitch_q < {2'd0, width_q[c2p_pkg::WidthW-1:3]}) begin
      check_code = c2p_pkg::ST_BAD_STRIDE;
    end else begin
      check_code = c2p_pkg::ST_OK;
    end
  end

  // Block and row position
  assign blocks     = width_q[c2p_pkg::WidthW-1:5];
  assign row_end    = ({1'b0, blk_q} + 8'd1) >= blocks;
  assign frame_end  = row_end && (({1'b0, row_q} + 13'd1) >= height_q);
  assign block_done = fmt_q ? (wc_q == 2'd3) : (wc_q != 2'd0);
  assign buf_idx    = (wc_q == 2'd3) ? 2'd0 : wc_q;

  // Next state and result
  always_comb begin
    running_d = running_q;
    wc_d      = wc_q;
    blk_d     = blk_q;
    row_d     = row_q;
    base_d    = base_q;
    buf_we    = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      if (in_i.command == c2p_pkg::CMD_START) begin
        running_d  = (check_code == c2p_pkg::ST_OK);
        wc_d       = 2'd0;
        blk_d      = '0;
        row_d      = '0;
        base_d     = '0;
        res_valid  = 1'b1;
        res.kind   = c2p_pkg::KIND_STATUS;
        res.status = check_code;
      end else if (!running_q) begin
        res_valid  = 1'b1;
        res.kind   = c2p_pkg::KIND_STATUS;
        res.status = c2p_pkg::ST_NOT_RUNNING;
      end else if (!block_done) begin
        buf_we = 1'b1;
        wc_d   = wc_q + 2'd1;
      end else begin
        res_valid       = 1'b1;
        res.kind        = c2p_pkg::KIND_BLOCK;
        res.status      = c2p_pkg::ST_OK;
        res.planes      = c2p_pkg::c2p_planes(fmt_q, buf_q[0], buf_q[1], buf_q[2],
                                              in_i.data_word);
        res.dest_offset = base_q + {15'd0, blk_q, 2'b00};
        res.last_block  = frame_end;
        wc_d            = 2'd0;
        if (frame_end) begin
          running_d = 1'b0;
          blk_d     = '0;
          row_d     = '0;
          base_d    = '0;
        end else if (row_end) begin
          blk_d  = '0;
          row_d  = row_q + 12'd1;
          base_d = base_q + {12'd0, pitch_q};
        end else begin
          blk_d = blk_q + 7'd1;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      wc_q      <= 2'd0;
      blk_q     <= '0;
      row_q     <= '0;
      base_q    <= '0;
    end else begin
      running_q <= running_d;
      wc_q      <= wc_d;
      blk_q     <= blk_d;
      row_q     <= row_d;
      base_q    <= base_d;
    end
  end

  // Buffer partial-block words
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[buf_idx] <= in_i.data_word;
    end
  end

  c2p_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb_chunky_to_planar_4bit_unit.sv
// Self-checking testbench of the 4-bit chunky-to-planar unit with its own block predictor.
`default_nettype none

module tb_chunky_to_planar_4bit_unit;
  import c2p_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 1950;
  localparam int MaxReports = 10;

  logic clk;
  logic rst_n;

  c2p_in_if  in_ch ();
  c2p_out_if res_ch ();
  c2p_cfg_if cfg_ch ();

  chunky_to_planar_4bit_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Predicted configuration registers
  logic               frame_fmt;
  logic [WidthW-1:0]  frame_width;
  logic [HeightW-1:0] frame_height;
  logic [StrideW-1:0] frame_stride;
  logic [PitchW-1:0]  frame_pitch;

  // Predicted conversion state
  logic               conv_running;
  logic [63:0]        conv_words [3];
  logic [1:0]         conv_count;
  logic [6:0]         conv_block;
  logic [11:0]        conv_row;
  logic [OffsetW-1:0] conv_row_base;

  result_t due_results [$];
  result_t want;

  int  items_sent = 0;
  int  mismatches = 0;
  int  n_blocks = 0;
  int  n_status = 0;
  int  n_frames = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  int  rx_wait = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  big_frame_done = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_chunky_to_planar_4bit_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_frame_state();
    frame_fmt     = 1'b0;
    frame_width   = 13'd32;
    frame_height  = 13'd1;
    frame_stride  = 16'd16;
    frame_pitch   = 12'd4;
    conv_running  = 1'b0;
    conv_count    = '0;
    conv_block    = '0;
    conv_row      = '0;
    conv_row_base = '0;
  endfunction

  // Validate the geometry; dimensions are judged before strides.
  function automatic logic [1:0] frame_check();
    logic [WidthW-1:0] row_bytes;
    row_bytes = frame_fmt ? frame_width : (frame_width >> 1);
    if (frame_width == 0 || frame_height == 0 || frame_width[4:0] != 5'd0 ||
        frame_width > MaxWidth || frame_height > MaxHeight) begin
      return ST_BAD_DIM;
    end
    if (frame_stride < row_bytes || frame_pitch < (frame_width >> 3)) begin
      return ST_BAD_STRIDE;
    end
    return ST_OK;
  endfunction

  // Advance the predicted state by one transaction; return 1 when it yields a result.
  function automatic bit convert_item(input logic cmd, input logic [63:0] word,
                                      output result_t r);
    int         words_needed;
    int         blocks;
    bit         row_end;
    bit         frame_end;
    logic [63:0] src;
    logic [3:0] px;
    planes_t    pl;
    r = '0;
    if (cmd == CMD_START) begin
      r.kind        = KIND_STATUS;
      r.status      = frame_check();
      conv_running  = (r.status == ST_OK);
      conv_count    = '0;
      conv_block    = '0;
      conv_row      = '0;
      conv_row_base = '0;
      return 1'b1;
    end
    if (!conv_running) begin
      r.kind   = KIND_STATUS;
      r.status = ST_NOT_RUNNING;
      return 1'b1;
    end

    // Hold the word until the block is complete
    words_needed = frame_fmt ? 4 : 2;
    if (int'(conv_count) + 1 < words_needed) begin
      conv_words[conv_count] = word;
      conv_count = conv_count + 2'd1;
      return 1'b0;
    end

    // Gather pixels in memory order and scatter their bits over the planes
    pl = '0;
    for (int i = 0; i < 32; i++) begin
      if (frame_fmt) begin
        src = (i / 8 == 3) ? word : conv_words[i / 8];
        px  = src[59 - 8 * (i % 8) -: 4];
      end else begin
        src = (i / 16 == 1) ? word : conv_words[0];
        px  = src[63 - 4 * (i % 16) -: 4];
      end
      for (int k = 0; k < Planes; k++) begin
        pl[k][31 - i] = px[k];
      end
    end

    blocks    = int'(frame_width >> 5);
    row_end   = (int'(conv_block) + 1) >= blocks;
    frame_end = row_end && ((int'(conv_row) + 1) >= int'(frame_height));

    r.kind        = KIND_BLOCK;
    r.status      = ST_OK;
    r.planes      = pl;
    r.dest_offset = conv_row_base + (OffsetW'(conv_block) << 2);
    r.last_block  = frame_end;

    conv_count = '0;
    if (frame_end) begin
      conv_running  = 1'b0;
      conv_block    = '0;
      conv_row      = '0;
      conv_row_base = '0;
    end else if (row_end) begin
      conv_block    = '0;
      conv_row      = conv_row + 12'd1;
      conv_row_base = conv_row_base + OffsetW'(frame_pitch);
    end else begin
      conv_block = conv_block + 7'd1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // Drive ready: long hold-off first, then the per-result stall
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off--;
      end else if (rx_wait > 0) begin
        res_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind %0d status %0d offset %06h",
                               res_ch.kind, res_ch.status, res_ch.dest_offset));
      end else begin
        want = due_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.status !== want.status ||
            res_ch.plane_zero !== want.planes[0] || res_ch.plane_one !== want.planes[1] ||
            res_ch.plane_two !== want.planes[2] || res_ch.plane_three !== want.planes[3] ||
            res_ch.dest_offset !== want.dest_offset ||
            res_ch.last_block !== want.last_block) begin
          log_mismatch($sformatf(
            {"kind %0d/%0d status %0d/%0d planes %08h %08h %08h %08h / ",
             "%08h %08h %08h %08h offset %06h/%06h last %0d/%0d (exp/got)"},
            want.kind, res_ch.kind, want.status, res_ch.status,
            want.planes[0], want.planes[1], want.planes[2], want.planes[3],
            res_ch.plane_zero, res_ch.plane_one, res_ch.plane_two, res_ch.plane_three,
            want.dest_offset, res_ch.dest_offset, want.last_block, res_ch.last_block));
        end
      end
      if (res_ch.kind === KIND_BLOCK) begin
        n_blocks++;
        if (res_ch.last_block === 1'b1) n_frames++;
      end else begin
        n_status++;
      end
      rx_wait = rx_idle_on ? $urandom_range(0, 8) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction, after a random gap while tx_idle_on is set, and predict its result
  task automatic send_item(input logic cmd, input logic [63:0] word);
    int      gap;
    result_t r;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_word <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (convert_item(cmd, word, r)) due_results.push_back(r);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_PIXEL_FORMAT:  frame_fmt    = val[0];
      REG_FRAME_WIDTH:   frame_width  = val[WidthW-1:0];
      REG_FRAME_HEIGHT:  frame_height = val[HeightW-1:0];
      REG_SOURCE_STRIDE: frame_stride = val[StrideW-1:0];
      REG_PLANE_PITCH:   frame_pitch  = val[PitchW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input logic fmt, input int w, input int h,
                           input int stride, input int pitch);
    wait_drained();
    write_reg(REG_PIXEL_FORMAT, CfgDataW'(fmt));
    write_reg(REG_FRAME_WIDTH, CfgDataW'(w));
    write_reg(REG_FRAME_HEIGHT, CfgDataW'(h));
    write_reg(REG_SOURCE_STRIDE, CfgDataW'(stride));
    write_reg(REG_PLANE_PITCH, CfgDataW'(pitch));
  endtask

  function automatic logic [63:0] random_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: data before any start, then a one-block packed frame
  task automatic test_idle_defaults();
    send_item(CMD_DATA, 64'h0123_4567_89ab_cdef);
    send_item(CMD_START, random_word());
    send_item(CMD_DATA, 64'hfedc_ba98_7654_3210);
    send_item(CMD_DATA, 64'h8421_8421_8421_8421);
  endtask

  // Geometry checks, each failure class and the exact passing boundaries
  task automatic test_start_checks();
    configure(1'b0, 0, 1, 0, 0);          // zero width wins over bad stride
    send_item(CMD_START, '0);
    configure(1'b0, 48, 1, 64, 8);        // width not a multiple of 32
    send_item(CMD_START, '0);
    configure(1'b0, 16'hffff, 1, 16'hffff, 12'hfff);
    send_item(CMD_START, '1);
    configure(1'b0, 64, 0, 32, 8);        // zero height
    send_item(CMD_START, '0);
    configure(1'b0, 64, 4097, 32, 8);     // height beyond the maximum
    send_item(CMD_START, '0);
    configure(1'b0, 64, 1, 31, 8);        // packed source row too short
    send_item(CMD_START, '0);
    configure(1'b1, 64, 1, 63, 8);        // byte-mode source row too short
    send_item(CMD_START, '0);
    configure(1'b1, 64, 1, 64, 7);        // plane rows overlap
    send_item(CMD_START, '0);
    configure(1'b1, MaxWidth, MaxHeight, MaxWidth, MaxWidth / 8);
    send_item(CMD_START, '0);
  endtask

  // Pixel extremes in both formats, restart mid-block, data after the frame
  task automatic test_pixel_patterns();
    configure(1'b0, 64, 1, 32, 8);
    send_item(CMD_START, '0);
    send_item(CMD_DATA, '0);
    send_item(CMD_DATA, '1);
    send_item(CMD_DATA, {16{4'ha}});
    send_item(CMD_DATA, {16{4'h5}});
    configure(1'b1, 32, 1, 32, 4);
    send_item(CMD_START, '0);
    send_item(CMD_DATA, '1);
    send_item(CMD_DATA, '1);
    send_item(CMD_START, random_word());  // drop the partial block
    send_item(CMD_DATA, {8{8'hf0}});      // high nibbles must be ignored
    send_item(CMD_DATA, 64'h0123_4567_89ab_cdef);
    send_item(CMD_DATA, 64'hfedc_ba98_7654_3210);
    send_item(CMD_DATA, {8{8'h3c}});
    send_item(CMD_DATA, random_word());
  endtask

  // Long receiver hold-off while the sender streams, a full drain, then random stalls and a second hold-off
  task automatic test_backpressure();
    configure(1'b0, 256, 4, 128, 32);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(CMD_START, '0);
    hold_off = 150;
    for (int i = 0; i < 40; i++) send_item(CMD_DATA, random_word());
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 24; i++) send_item(CMD_DATA, random_word());
    hold_off = 60;
    for (int i = 0; i < 12; i++) send_item(CMD_DATA, random_word());
  endtask

  // One random frame: mostly well-formed, sometimes broken or reconfigured
  task automatic run_frame();
    logic fmt;
    int   w;
    int   h;
    int   stride;
    int   pitch;
    int   total;
    int   cut;
    int   live_at;
    int   pause_at;
    fmt = 1'($urandom_range(0, 1));
    if (!big_frame_done && $urandom_range(0, 29) == 0) begin
      w = MaxWidth;
      h = 1;
      big_frame_done = 1'b1;
    end else begin
      w = 32 * $urandom_range(1, 8);
      h = $urandom_range(1, 4);
    end
    stride = (fmt ? w : w / 2) + $urandom_range(0, 64);
    pitch  = w / 8 + $urandom_range(0, 40);
    case ($urandom_range(0, 19))
      0: stride = $urandom_range(0, 65535);
      1: pitch  = $urandom_range(0, 4095);
      2: stride = (fmt ? w : w / 2) - 1;
      3: pitch  = w / 8 - 1;
      4: w      = w + 16;
      5: h      = 0;
      default: ;
    endcase
    configure(fmt, w, h, stride, pitch);
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 19) == 0) hold_off = $urandom_range(20, 120);
    send_item(CMD_START, random_word());

    // Rejected start: data must be refused
    if (!conv_running) begin
      repeat ($urandom_range(1, 2)) send_item(CMD_DATA, random_word());
      return;
    end

    total    = (w / 32) * h * (fmt ? 4 : 2);
    cut      = ($urandom_range(0, 24) == 0) ? $urandom_range(0, total - 1) : total;
    live_at  = ($urandom_range(0, 14) == 0) ? $urandom_range(0, total - 1) : -1;
    pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < cut; i++) begin
      if (i == pause_at) wait_drained();
      if (i == live_at) begin
        wait_drained();
        write_reg(REG_PLANE_PITCH, CfgDataW'($urandom_range(0, 4095)));
        if ($urandom_range(0, 1) == 1) write_reg(REG_PIXEL_FORMAT, CfgDataW'(~fmt));
      end
      send_item(CMD_DATA, random_word());
    end
    if (cut < total) begin
      send_item(CMD_START, random_word());
    end else if ($urandom_range(0, 4) == 0) begin
      send_item(CMD_DATA, random_word());
    end
  endtask

  task automatic test_random_frames();
    while (items_sent < ItemTarget) run_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_DATA;
    in_ch.data_word  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_PIXEL_FORMAT;
    cfg_ch.wr_data   = '0;
    reset_frame_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_idle_defaults();
    test_start_checks();
    test_pixel_patterns();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions; checked %0d plane blocks and %0d status responses.",
             items_sent, n_blocks, n_status);
    $display("Completed %0d frames; %0d mismatches, %0d results still due.",
             n_frames, mismatches, due_results.size());
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb_chunky_to_planar_4bit_unit: PASS");
    end else begin
      $display("tb_chunky_to_planar_4bit_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
